// ===== rtl/lobm_pkg.sv =====
// Shared types and codes for the limit order book matcher.
`timescale 1ns / 1ps

package lobm_pkg;

	localparam int PRICE_W = 8;
	localparam int QTY_W   = 16;
	localparam int ID_W    = 32;
	localparam int KIND_W  = 3;

	localparam logic REQ_ADD    = 1'b0;
	localparam logic REQ_CANCEL = 1'b1;
	localparam logic SIDE_BUY   = 1'b0;
	localparam logic SIDE_SELL  = 1'b1;

	localparam logic [KIND_W-1:0] KIND_TRADE      = 3'd0;
	localparam logic [KIND_W-1:0] KIND_ADD_DONE   = 3'd1;
	localparam logic [KIND_W-1:0] KIND_ADD_REJECT = 3'd2;
	localparam logic [KIND_W-1:0] KIND_CANCELLED  = 3'd3;
	localparam logic [KIND_W-1:0] KIND_NOT_FOUND  = 3'd4;
	localparam logic [KIND_W-1:0] KIND_BOOK_FULL  = 3'd5;

	typedef struct packed {
		logic               req_type;
		logic               side;
		logic [PRICE_W-1:0] price;
		logic [QTY_W-1:0]   quantity;
		logic [ID_W-1:0]    order_id;
	} in_item_t;

	typedef struct packed {
		logic [KIND_W-1:0]  kind;
		logic [ID_W-1:0]    maker_id;
		logic [ID_W-1:0]    taker_id;
		logic [QTY_W-1:0]   exec_quantity;
		logic [PRICE_W-1:0] exec_price;
		logic               taker_side;
		logic [QTY_W-1:0]   remaining_quantity;
		logic [PRICE_W-1:0] best_bid;
		logic [PRICE_W-1:0] best_ask;
		logic               last;
	} out_item_t;

	typedef enum logic [1:0] {
		SCAN_FREE,
		SCAN_ID,
		SCAN_LEVEL
	} scan_mode_t;

endpackage

// ===== rtl/lobm_chan_if.sv =====
// Valid/ready channel carrying one item per handshake.
`timescale 1ns / 1ps

interface lobm_chan_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// ===== rtl/lobm_scan.sv =====
// Slot search unit: lowest matching slot and best bid/ask over all slots.
`timescale 1ns / 1ps

module lobm_scan #(
	parameter int N  = 32,
	parameter int SW = 5
) (
	input  lobm_pkg::scan_mode_t        mode,
	input  logic [lobm_pkg::ID_W-1:0]    key_id,
	input  logic                         key_side,
	input  logic [lobm_pkg::PRICE_W-1:0] key_price,
	input  logic                         valid [N],
	input  logic [lobm_pkg::ID_W-1:0]    ident [N],
	input  logic                         sside [N],
	input  logic [lobm_pkg::PRICE_W-1:0] sprice [N],
	output logic                         found,
	output logic [SW-1:0]                idx,
	output logic [lobm_pkg::PRICE_W-1:0] best_bid,
	output logic [lobm_pkg::PRICE_W-1:0] best_ask
);
	import lobm_pkg::*;

	localparam int NP = 1 << SW;

	logic               hit_t [2*NP];
	logic [SW-1:0]      idx_t [2*NP];
	logic [PRICE_W-1:0] bid_t [2*NP];
	logic [PRICE_W:0]   ask_t [2*NP];

	always_comb begin
		for (int i = 0; i < 2*NP; i++) begin
			hit_t[i] = 1'b0;
			idx_t[i] = '0;
			bid_t[i] = '0;
			ask_t[i] = '0;
		end
		for (int i = 0; i < N; i++) begin
			unique case (mode)
				SCAN_FREE:  hit_t[NP+i] = !valid[i];
				SCAN_ID:    hit_t[NP+i] = valid[i] && (ident[i] == key_id);
				SCAN_LEVEL: hit_t[NP+i] = valid[i] && (sside[i] == key_side)
					&& (sprice[i] == key_price);
				default:    hit_t[NP+i] = 1'b0;
			endcase
			idx_t[NP+i] = SW'(i);
			bid_t[NP+i] = (valid[i] && sside[i] == SIDE_BUY) ? sprice[i] : '0;
			// top bit marks a resting ask so that price 255 is not lost
			ask_t[NP+i] = (valid[i] && sside[i] == SIDE_SELL) ? {1'b1, ~sprice[i]} : '0;
		end
		// reduce pairwise; lower index wins ties
		for (int i = NP - 1; i >= 1; i--) begin
			hit_t[i] = hit_t[2*i] || hit_t[2*i+1];
			idx_t[i] = hit_t[2*i] ? idx_t[2*i] : idx_t[2*i+1];
			bid_t[i] = (bid_t[2*i] > bid_t[2*i+1]) ? bid_t[2*i] : bid_t[2*i+1];
			ask_t[i] = (ask_t[2*i] > ask_t[2*i+1]) ? ask_t[2*i] : ask_t[2*i+1];
		end
	end

	assign found    = hit_t[1];
	assign idx      = idx_t[1];
	assign best_bid = bid_t[1];
	assign best_ask = ask_t[1][PRICE_W] ? ~ask_t[1][PRICE_W-1:0] : '0;

endmodule

// ===== rtl/limit_order_book_matcher.sv =====
// Top level of the price-time priority limit order book matcher.
`timescale 1ns / 1ps

// Usage:
//   in_ch carries one request item (add or cancel); out_ch returns the result
//   items it causes: one trade item per fill, then one final item with last=1
//   that carries status plus best bid and best ask after the request.
//   in_ch.ready is high only while the sequencer sits idle; one request is
//   worked at a time.
// Request steps:
//   cancel: find, unlink, load into the result register; find, load if absent.
//   add: per fill, best-price pick and level read, fill, load; then to rest the
//   remainder: pick, free slot, level read, insert, load. A fully filled add
//   ends with a pick and a load; a reject goes straight to load.
//   The level head/tail memory read port and the single slot search unit set
//   these steps.
// Reset:
//   arst_n clears the sequencer, the output valid bit, the slot valid bits and the id counter (1).
//   Level memory needs no clearing: a level is read only while a slot rests
//   there, and best prices come from the slot valid bits.
// Stall:
//   a single output register holds each result item; while it holds an item and
//   out_ch.ready is low, the sequencer waits before loading the next item.

module limit_order_book_matcher #(
	parameter int PRICE_LEVELS = 256,
	parameter int ORDER_SLOTS  = 32
) (
	input  logic    clk,
	input  logic    arst_n,
	lobm_chan_if.sink   in_ch,
	lobm_chan_if.source out_ch
);
	import lobm_pkg::*;

	localparam int SW  = $clog2(ORDER_SLOTS);
	localparam int PW  = $clog2(PRICE_LEVELS);
	localparam int PWX = (PW > PRICE_W) ? PW : PRICE_W;
	localparam int LW  = PW + 1;
	localparam int LVL_DEPTH = 1 << LW;

	typedef enum logic [8:0] {
		ST_IDLE  = 9'b000000001,
		ST_MATCH = 9'b000000010,
		ST_HEAD  = 9'b000000100,
		ST_FREE  = 9'b000001000,
		ST_LVL   = 9'b000010000,
		ST_INS   = 9'b000100000,
		ST_CFIND = 9'b001000000,
		ST_CUNL  = 9'b010000000,
		ST_LOAD  = 9'b100000000
	} state_t;

	state_t state_q;

	// request context
	logic               side_q;
	logic [PRICE_W-1:0] price_q;
	logic [QTY_W-1:0]   qty_q;
	logic [ID_W-1:0]    cid_q;
	logic [ID_W-1:0]    id_q;
	logic [ID_W-1:0]    next_id_q;
	logic [SW-1:0]      slot_q;
	logic               lvl_ne_q;
	logic [LW-1:0]      lv_q;
	out_item_t          pend_q;
	out_item_t          out_q;
	logic               out_valid_q;

	// resting order slots
	logic               sv_q     [ORDER_SLOTS];
	logic [ID_W-1:0]    sid_q    [ORDER_SLOTS];
	logic [QTY_W-1:0]   sqty_q   [ORDER_SLOTS];
	logic [PRICE_W-1:0] sprice_q [ORDER_SLOTS];
	logic               sside_q  [ORDER_SLOTS];
	logic [SW-1:0]      snext_q  [ORDER_SLOTS];
	logic [SW-1:0]      sprev_q  [ORDER_SLOTS];

	// level memory: {head, tail} per side and price
	logic [2*SW-1:0] lvl_mem [LVL_DEPTH];
	logic [2*SW-1:0] rd_q;
	logic [LW-1:0]   mem_ra;
	logic            mem_we;
	logic [2*SW-1:0] mem_wd;

	// search unit
	scan_mode_t         scan_mode;
	logic               scan_found;
	logic [SW-1:0]      scan_idx;
	logic [PRICE_W-1:0] best_bid;
	logic [PRICE_W-1:0] best_ask;

	lobm_scan #(.N(ORDER_SLOTS), .SW(SW)) u_scan (
		.mode      (scan_mode),
		.key_id    (cid_q),
		.key_side  (side_q),
		.key_price (price_q),
		.valid     (sv_q),
		.ident     (sid_q),
		.sside     (sside_q),
		.sprice    (sprice_q),
		.found     (scan_found),
		.idx       (scan_idx),
		.best_bid  (best_bid),
		.best_ask  (best_ask)
	);

	always_comb begin
		unique case (state_q)
			ST_FREE:  scan_mode = SCAN_FREE;
			ST_CFIND: scan_mode = SCAN_ID;
			default:  scan_mode = SCAN_LEVEL;
		endcase
	end

	// level addresses: side bit over the price narrowed to the level range
	logic [PWX-1:0]     px_req, px_bp, px_slot;
	logic [PRICE_W-1:0] bp;
	logic               in_acc;
	logic               invalid_add;
	logic               stop_match;

	assign in_acc = in_ch.valid && in_ch.ready;
	assign invalid_add = (in_ch.data.price == '0) || (in_ch.data.quantity == '0)
		|| (32'(in_ch.data.price) >= 32'(PRICE_LEVELS));
	assign bp = (side_q == SIDE_BUY) ? best_ask : best_bid;
	assign stop_match = (bp == '0) || ((side_q == SIDE_BUY) ? (bp > price_q) : (bp < price_q));
	assign px_req  = PWX'(price_q);
	assign px_bp   = PWX'(bp);
	assign px_slot = PWX'(sprice_q[scan_idx]);

	always_comb begin
		unique case (state_q)
			ST_MATCH: mem_ra = {~side_q, px_bp[PW-1:0]};
			ST_CFIND: mem_ra = {sside_q[scan_idx], px_slot[PW-1:0]};
			default:  mem_ra = {side_q, px_req[PW-1:0]};
		endcase
	end

	// fill arithmetic on the level head
	logic [SW-1:0]    hd, tl;
	logic [QTY_W-1:0] rq, fill, qty_after;
	assign hd = rd_q[2*SW-1:SW];
	assign tl = rd_q[SW-1:0];
	assign rq = sqty_q[hd];
	assign fill = (qty_q < rq) ? qty_q : rq;
	assign qty_after = qty_q - fill;

	// unlink of one slot from its level
	logic          unl_en;
	logic [SW-1:0] u;
	assign u = (state_q == ST_HEAD) ? hd : slot_q;
	assign unl_en = ((state_q == ST_HEAD) && (fill == rq)) || (state_q == ST_CUNL);

	always_comb begin
		mem_we = 1'b0;
		mem_wd = rd_q;
		if (unl_en && hd != tl) begin
			if (u == hd) begin
				mem_we = 1'b1;
				mem_wd = {snext_q[u], tl};
			end else if (u == tl) begin
				mem_we = 1'b1;
				mem_wd = {hd, sprev_q[u]};
			end
		end else if (state_q == ST_INS) begin
			mem_we = 1'b1;
			mem_wd = lvl_ne_q ? {hd, slot_q} : {slot_q, slot_q};
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			lvl_mem[lv_q] <= mem_wd;
		end
		rd_q <= lvl_mem[mem_ra];
	end

	// slot payload
	always_ff @(posedge clk) begin
		if (state_q == ST_HEAD && fill != rq) begin
			sqty_q[hd] <= rq - fill;
		end
		if (unl_en && hd != tl && u != hd && u != tl) begin
			snext_q[sprev_q[u]] <= snext_q[u];
			sprev_q[snext_q[u]] <= sprev_q[u];
		end
		if (state_q == ST_INS) begin
			sid_q[slot_q]    <= id_q;
			sqty_q[slot_q]   <= qty_q;
			sprice_q[slot_q] <= price_q;
			sside_q[slot_q]  <= side_q;
			snext_q[slot_q]  <= '0;
			sprev_q[slot_q]  <= lvl_ne_q ? tl : '0;
			if (lvl_ne_q) begin
				snext_q[tl] <= slot_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ORDER_SLOTS; i++) begin
				sv_q[i] <= 1'b0;
			end
		end else begin
			if (unl_en) begin
				sv_q[u] <= 1'b0;
			end
			if (state_q == ST_INS) begin
				sv_q[slot_q] <= 1'b1;
			end
		end
	end

	// request context and pending item; no reset needed
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				side_q  <= in_ch.data.side;
				price_q <= in_ch.data.price;
				qty_q   <= in_ch.data.quantity;
				cid_q   <= in_ch.data.order_id;
				id_q    <= next_id_q;
				pend_q  <= '0;
				pend_q.kind       <= KIND_ADD_REJECT;
				pend_q.taker_side <= in_ch.data.side;
				pend_q.last       <= 1'b1;
			end
			ST_MATCH: begin
				lv_q   <= mem_ra;
				pend_q <= '0;
				pend_q.kind       <= KIND_ADD_DONE;
				pend_q.taker_id   <= id_q;
				pend_q.taker_side <= side_q;
				pend_q.last       <= 1'b1;
			end
			ST_HEAD: begin
				qty_q  <= qty_after;
				pend_q <= '0;
				pend_q.kind               <= KIND_TRADE;
				pend_q.maker_id           <= sid_q[hd];
				pend_q.taker_id           <= id_q;
				pend_q.exec_quantity      <= fill;
				pend_q.exec_price         <= sprice_q[hd];
				pend_q.taker_side         <= side_q;
				pend_q.remaining_quantity <= qty_after;
			end
			ST_FREE: begin
				slot_q <= scan_idx;
				pend_q <= '0;
				pend_q.kind               <= KIND_BOOK_FULL;
				pend_q.taker_id           <= id_q;
				pend_q.taker_side         <= side_q;
				pend_q.remaining_quantity <= qty_q;
				pend_q.last               <= 1'b1;
			end
			ST_LVL: begin
				lvl_ne_q <= scan_found;
				lv_q     <= mem_ra;
			end
			ST_INS: begin
				pend_q.kind <= KIND_ADD_DONE;
			end
			ST_CFIND: begin
				slot_q <= scan_idx;
				lv_q   <= mem_ra;
				pend_q <= '0;
				pend_q.kind     <= scan_found ? KIND_CANCELLED : KIND_NOT_FOUND;
				pend_q.taker_id <= cid_q;
				pend_q.last     <= 1'b1;
			end
			default: begin
			end
		endcase
	end

	// sequencer, id counter and output register
	logic load_ok;
	assign load_ok = !out_valid_q || out_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			next_id_q   <= 32'd1;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (in_ch.data.req_type == REQ_CANCEL) begin
							state_q <= ST_CFIND;
						end else if (invalid_add) begin
							state_q <= ST_LOAD;
						end else begin
							next_id_q <= next_id_q + 32'd1;
							state_q   <= ST_MATCH;
						end
					end
				end
				ST_MATCH: begin
					if (qty_q == '0) begin
						state_q <= ST_LOAD;
					end else if (stop_match) begin
						state_q <= ST_FREE;
					end else begin
						state_q <= ST_HEAD;
					end
				end
				ST_HEAD:  state_q <= ST_LOAD;
				ST_FREE:  state_q <= scan_found ? ST_LVL : ST_LOAD;
				ST_LVL:   state_q <= ST_INS;
				ST_INS:   state_q <= ST_LOAD;
				ST_CFIND: state_q <= scan_found ? ST_CUNL : ST_LOAD;
				ST_CUNL:  state_q <= ST_LOAD;
				ST_LOAD: begin
					if (load_ok) begin
						out_valid_q <= 1'b1;
						state_q     <= pend_q.last ? ST_IDLE : ST_MATCH;
					end
				end
				default:  state_q <= ST_IDLE;
			endcase
		end
	end

	// bests are taken after the slot update has settled
	always_ff @(posedge clk) begin
		if (state_q == ST_LOAD && load_ok) begin
			out_q          <= pend_q;
			out_q.best_bid <= best_bid;
			out_q.best_ask <= best_ask;
		end
	end

	assign in_ch.ready  = (state_q == ST_IDLE);
	assign out_ch.valid = out_valid_q;
	assign out_ch.data  = out_q;

`ifndef SYNTH
	a_trade_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.kind == KIND_TRADE) |-> !out_q.last)
		else $error("trade item marked last");
	a_trade_qty: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.kind == KIND_TRADE) |-> (out_q.exec_quantity != '0))
		else $error("trade with zero quantity");
	a_id_step: assert property (@(posedge clk) disable iff (!arst_n)
		!in_acc |=> $stable(next_id_q))
		else $error("id advanced without a request");
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LOAD && !load_ok) |=> $stable(out_q))
		else $error("held result item changed");
`endif

endmodule
